FILE: rtl/core/flptw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// flptw_pkg: shared types and constants of the page table walker
// Item formats, control and status bundles, action and register codes.
// ----------------------------------------------------------------------------
package flptw_pkg;

	localparam int STORE_DEPTH_DEF = 256;

	localparam int VA_W     = 48;
	localparam int PA_W     = 52;
	localparam int WORD_W   = 64;
	localparam int FRAME_LO = 12;
	localparam int FRAME_HI = 51;
	localparam int FRAME_W  = FRAME_HI - FRAME_LO + 1;
	localparam int OFFS_W   = 12;
	localparam int IDX_W    = 9;
	localparam int PAD_W    = WORD_W - FRAME_HI - 1;
	localparam int PRESENT  = 0;

	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 64;
	localparam int REG_SEL    = 3;

	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_XLATE = 1'b1;

	localparam logic REG_ROOT = 1'b0;

	typedef logic [1:0] level_t;
	localparam level_t LAST_LEVEL = 2'd3;

	typedef struct packed {
		logic              action;
		logic [WORD_W-1:0] mem_address;
		logic [WORD_W-1:0] mem_value;
		logic [VA_W-1:0]   virtual_address;
	} in_item_t;

	typedef struct packed {
		logic [PA_W-1:0] physical_address;
		logic            fault;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic start;
		logic scan;
		logic next_level;
		logic finish;
		logic push;
	} dp_cmd_t;

	typedef struct packed {
		logic hit;
		logic miss;
		logic present;
		logic last_level;
		logic out_free;
	} dp_sts_t;

	function automatic logic [IDX_W-1:0] va_index(input logic [VA_W-1:0] va, input level_t lvl);
		logic [IDX_W-1:0] idx;
		unique case (lvl)
			2'd0: idx = va[47:39];
			2'd1: idx = va[38:30];
			2'd2: idx = va[29:21];
			default: idx = va[20:12];
		endcase
		return idx;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/four_level_page_table_walker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// four_level_page_table_walker: four-level page table walk over a pair store
// Items arrive on in_valid/in_ready as in_item_t. A load item appends an
// (address, value) pair to the store; pairs past the store depth are
// dropped. A translate item walks up to four table levels starting from the
// root_entry register and yields one out_item_t transfer on
// out_valid/out_ready; it stops early, with a fault, at an entry that is
// missing or not present. Each level scans the stored pairs in load order,
// one pair per cycle through the registered store read port, and stops at
// the first match; a level with no match ends the walk with a fault. One
// item is worked on at a time; the result sits in an output register, so a
// load or a new translation is taken while an earlier result waits, and a
// finished walk waits only while that register is still full. root_entry is
// written over the APB port at any byte address with paddr bit 3 clear; the
// user must write it only while the block is idle, which the block itself
// does not enforce. Reset clears the store fill count, root_entry and all
// handshake state.
// ----------------------------------------------------------------------------
module four_level_page_table_walker import flptw_pkg::*; #(
	parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire in_item_t              in_data,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output out_item_t                  out_data,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0]      prdata,
	output logic                       pready
);

	logic [WORD_W-1:0] root_q;
	logic              reg_wr;
	dp_cmd_t           cmd;
	dp_sts_t           sts;

	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite && pready && (paddr[REG_SEL] == REG_ROOT);
	assign prdata = (paddr[REG_SEL] == REG_ROOT) ? root_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q <= '0;
		end else if (reg_wr) begin
			root_q <= pwdata;
		end
	end

	flptw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_action (in_data.action),
		.in_ready  (in_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	flptw_dp #(
		.STORE_DEPTH(STORE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.root      (root_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

FILE: rtl/core/flptw_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// flptw_ctrl: walk sequencer
// Accepts items, steps the datapath through up to four table levels and
// hands each finished translation to the output register.
// ----------------------------------------------------------------------------
module flptw_ctrl import flptw_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	input  wire logic    in_action,
	output logic         in_ready,
	input  wire dp_sts_t sts,
	output dp_cmd_t      cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t state_q;

	always_comb begin
		in_ready       = (state_q == ST_IDLE);
		cmd            = '0;
		cmd.load       = in_ready && in_valid && (in_action == ACT_LOAD);
		cmd.start      = in_ready && in_valid && (in_action == ACT_XLATE);
		cmd.scan       = (state_q == ST_SCAN);
		cmd.next_level = cmd.scan && sts.hit && sts.present && !sts.last_level;
		cmd.finish     = cmd.scan && (sts.miss ||
			(sts.hit && (!sts.present || sts.last_level)));
		cmd.push       = (state_q == ST_DONE) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.start) state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (cmd.finish) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (cmd.push) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_hit_miss_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(sts.hit && sts.miss))
		else $error("Lookup reported both a match and a miss.");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> (state_q == ST_SCAN))
		else $error("Walk start did not enter the scan state.");

	a_finish_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> (state_q == ST_DONE))
		else $error("Finished walk did not wait for the output register.");

endmodule
`default_nettype wire

FILE: rtl/core/flptw_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// flptw_dp: walk datapath
// Word pair store, ordered first-match scan, level registers, result and
// output registers.
// ----------------------------------------------------------------------------
module flptw_dp import flptw_pkg::*; #(
	parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dp_cmd_t           cmd,
	output dp_sts_t                sts,
	input  wire in_item_t          in_data,
	input  wire logic [WORD_W-1:0] root,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output out_item_t              out_data
);

	localparam int MEM_IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int CNT_W     = $clog2(STORE_DEPTH + 1);

	logic [WORD_W-1:0] mem_addr [STORE_DEPTH];
	logic [WORD_W-1:0] mem_val  [STORE_DEPTH];

	logic [CNT_W-1:0]   fill_q;
	logic [CNT_W-1:0]   k_q;
	logic               rd_vld_s1;
	logic [WORD_W-1:0]  rd_addr_s1;
	logic [WORD_W-1:0]  rd_val_s1;
	logic [VA_W-1:0]    va_q;
	logic [FRAME_W-1:0] frame_q;
	level_t             level_q;
	out_item_t          res_q;
	out_item_t          out_q;
	logic               out_valid_q;

	logic [WORD_W-1:0]  lkp_addr;
	logic               can_write;
	logic               can_read;
	logic               good;

	assign lkp_addr  = {{PAD_W{1'b0}}, frame_q, va_index(va_q, level_q), 3'b000};
	assign can_write = (fill_q < CNT_W'(STORE_DEPTH));
	assign can_read  = (k_q < fill_q);

	always_comb begin
		sts.hit        = rd_vld_s1 && (rd_addr_s1 == lkp_addr);
		sts.miss       = !rd_vld_s1 && (k_q == fill_q);
		sts.present    = rd_val_s1[PRESENT];
		sts.last_level = (level_q == LAST_LEVEL);
		sts.out_free   = !out_valid_q || out_ready;
		good           = sts.hit && sts.present;
	end

	always_ff @(posedge clk) begin
		if (cmd.load && can_write) begin
			mem_addr[fill_q[MEM_IDX_W-1:0]] <= in_data.mem_address;
			mem_val[fill_q[MEM_IDX_W-1:0]]  <= in_data.mem_value;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			rd_addr_s1 <= mem_addr[k_q[MEM_IDX_W-1:0]];
			rd_val_s1  <= mem_val[k_q[MEM_IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			k_q         <= '0;
			rd_vld_s1   <= 1'b0;
			level_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load && can_write) fill_q <= fill_q + CNT_W'(1);
			if (cmd.start || cmd.next_level) begin
				k_q       <= '0;
				rd_vld_s1 <= 1'b0;
			end else if (cmd.scan && can_read) begin
				k_q       <= k_q + CNT_W'(1);
				rd_vld_s1 <= 1'b1;
			end else begin
				rd_vld_s1 <= 1'b0;
			end
			if (cmd.start) level_q <= '0;
			else if (cmd.next_level) level_q <= level_q + 2'd1;
			if (cmd.push) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			va_q    <= in_data.virtual_address;
			frame_q <= root[FRAME_HI:FRAME_LO];
		end else if (cmd.next_level) begin
			frame_q <= rd_val_s1[FRAME_HI:FRAME_LO];
		end
		if (cmd.finish) begin
			res_q.fault            <= !good;
			res_q.physical_address <= good ?
				{rd_val_s1[FRAME_HI:FRAME_LO], va_q[OFFS_W-1:0]} : '0;
		end
		if (cmd.push) out_q <= res_q;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(STORE_DEPTH))
		else $error("Store fill count ran past the store depth.");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		k_q <= fill_q)
		else $error("Scan pointer ran past the filled part of the store.");

	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (!out_valid_q || out_ready))
		else $error("Result overwrote an output that was not transferred.");

	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.fault) |-> (out_q.physical_address == '0))
		else $error("Faulting result carries a nonzero address.");

endmodule
`default_nettype wire
